// ----- hdl/bba_pkg.sv -----
// Shared constants, codes and control types of the bitmap block allocator.
package bba_pkg;

  localparam int BLOCK_W        = 13;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int MAP_WORD_W     = 64;
  localparam int BIT_IDX_W      = $clog2(MAP_WORD_W);
  localparam int MAX_BLOCKS_DEF = 4096;

  localparam logic [BLOCK_W-1:0] BLOCK_COUNT_RST = BLOCK_W'(4096);

  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FORMAT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Superblock and root ahead of the inode area.
  localparam int META_FIXED = 1 + 1;
  localparam int INODE_DIV  = 10;

  // Ceiling division by ten as a multiplication by a scaled reciprocal.
  localparam int RECIP_SH  = 16;
  localparam int RECIP_10  = (1 << RECIP_SH) / INODE_DIV + 1;
  localparam int RECIP_W   = $clog2(RECIP_10 + 1);
  localparam int SUM_W     = BLOCK_W + 1;
  localparam int MUL_W     = SUM_W + RECIP_W;
  localparam int RSV_W     = MUL_W - RECIP_SH;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic free_wr;
    logic fmt_mul;
    logic fmt_rsv;
    logic sweep;
    logic sweep_zero;
    logic res_zero;
    logic res_full;
    logic res_range;
    logic out_load;
  } bba_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic found;
    logic exhausted;
    logic bn_bad;
    logic sweep_last;
  } bba_sts_t;

endpackage

// ----- hdl/bba_if.sv -----
// Valid/ready channel interfaces for request and result words.
interface bba_in_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [BLOCK_W-1:0] block_number;

  modport source (output valid, output func, output block_number, input ready);
  modport sink   (input valid, input func, input block_number, output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;

  logic                valid;
  logic                ready;
  logic [BLOCK_W-1:0]  granted_block;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink   (input valid, input granted_block, input status, output ready);
endinterface

// ----- hdl/bba_datapath.sv -----
// Datapath of the allocator: bitmap memory, scan, free, format and result registers.
module bba_datapath #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bba_pkg::BLOCK_W-1:0]    cfg_wr_data,
  input  logic [bba_pkg::BLOCK_W-1:0]    in_block_number,
  input  bba_pkg::bba_cmd_t              cmd,
  output bba_pkg::bba_sts_t              sts,
  output logic [bba_pkg::BLOCK_W-1:0]    out_granted_block,
  output logic [bba_pkg::STATUS_W-1:0]   out_status
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = ((AW + BIT_IDX_W > RSV_W) ? AW + BIT_IDX_W : RSV_W) + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [MAP_WORD_W-1:0] v);
    logic [BIT_IDX_W-1:0] pos;
    pos = '0;
    for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_IDX_W'(i);
      end
    end
    return pos;
  endfunction

  logic [MAP_WORD_W-1:0] mem [MAP_WORDS];

  logic [BLOCK_W-1:0]    block_count_r;
  logic [BLOCK_W-1:0]    bn_r;
  logic [AW-1:0]         scan_addr_r;
  logic                  issue_done_r;
  logic                  chk_v_r;
  logic [AW-1:0]         chk_idx_r;
  logic [MAP_WORD_W-1:0] rdata_r;
  logic [MUL_W-1:0]      prod_r;
  logic [RSV_W-1:0]      reserve_r;
  logic [AW-1:0]         sweep_addr_r;
  logic [BLOCK_W-1:0]    res_granted_r;
  logic [STATUS_W-1:0]   res_status_r;
  logic [BLOCK_W-1:0]    out_granted_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [BLOCK_W-1:0]    n;
  logic [AW-1:0]         last_w;
  logic [6:0]            last_cnt;
  logic [MAP_WORD_W-1:0] last_mask;
  logic [MAP_WORD_W-1:0] free_bits;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic                  any_free;
  logic [BLOCK_W-1:0]    bn_idx;
  logic [AW-1:0]         free_word;
  logic [BIT_IDX_W-1:0]  free_bit;
  logic [CW-1:0]         sw_base;
  logic [CW-1:0]         sw_rsv;
  logic [CW-1:0]         sw_diff;
  logic [MAP_WORD_W-1:0] sweep_mask;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MAP_WORD_W-1:0] wr_data;

  assign n = (32'(block_count_r) > MAX_BLOCKS) ? BLOCK_W'(MAX_BLOCKS) : block_count_r;

  assign last_w    = AW'((n - BLOCK_W'(1)) >> BIT_IDX_W);
  assign last_cnt  = 7'((n - BLOCK_W'(1)) & BLOCK_W'(MAP_WORD_W - 1)) + 7'd1;
  assign last_mask = (last_cnt == 7'(MAP_WORD_W)) ? '1
                     : ((MAP_WORD_W'(1) << last_cnt) - MAP_WORD_W'(1));

  assign free_bits = ~rdata_r & ((chk_idx_r == last_w) ? last_mask : '1);
  assign any_free  = |free_bits;
  assign hit_bit   = lowest_set(free_bits);

  assign bn_idx    = bn_r - BLOCK_W'(1);
  assign free_word = AW'(bn_idx >> BIT_IDX_W);
  assign free_bit  = bn_idx[BIT_IDX_W-1:0];

  always_comb begin
    sw_base    = CW'({sweep_addr_r, {BIT_IDX_W{1'b0}}});
    sw_rsv     = CW'(reserve_r);
    sw_diff    = sw_rsv - sw_base;
    sweep_mask = '0;
    if (sw_rsv >= sw_base + CW'(MAP_WORD_W)) begin
      sweep_mask = '1;
    end else if (sw_rsv > sw_base) begin
      sweep_mask = (MAP_WORD_W'(1) << sw_diff[BIT_IDX_W-1:0]) - MAP_WORD_W'(1);
    end
  end

  assign rd_addr = cmd.scan ? scan_addr_r : free_word;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_addr_r;
    wr_data = cmd.sweep_zero ? '0 : sweep_mask;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.scan && chk_v_r && any_free) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx_r;
      wr_data = rdata_r | (MAP_WORD_W'(1) << hit_bit);
    end else if (cmd.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = free_word;
      wr_data = rdata_r & ~(MAP_WORD_W'(1) << free_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BLOCK_COUNT_RST;
      sweep_addr_r  <= '0;
      chk_v_r       <= 1'b0;
      issue_done_r  <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        block_count_r <= cfg_wr_data;
      end
      if (cmd.sweep) begin
        sweep_addr_r <= (sweep_addr_r == LAST_WORD) ? '0 : sweep_addr_r + AW'(1);
      end
      if (cmd.scan_start) begin
        issue_done_r <= 1'b0;
        chk_v_r      <= 1'b0;
      end else if (cmd.scan) begin
        chk_v_r <= !issue_done_r;
        if (!issue_done_r && scan_addr_r >= last_w) begin
          issue_done_r <= 1'b1;
        end
      end else begin
        chk_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bn_r <= in_block_number;
    end
    if (cmd.scan_start) begin
      scan_addr_r <= '0;
    end else if (cmd.scan && !issue_done_r) begin
      chk_idx_r   <= scan_addr_r;
      scan_addr_r <= scan_addr_r + AW'(1);
    end
    if (cmd.fmt_mul) begin
      prod_r <= (MUL_W'(n) + MUL_W'(INODE_DIV - 1)) * MUL_W'(RECIP_10);
    end
    if (cmd.fmt_rsv) begin
      reserve_r <= prod_r[MUL_W-1:RECIP_SH] + RSV_W'(META_FIXED);
    end
    if (cmd.scan && chk_v_r && any_free) begin
      res_granted_r <= BLOCK_W'({chk_idx_r, hit_bit}) + BLOCK_W'(1);
      res_status_r  <= ST_OK;
    end else if ((cmd.scan && chk_v_r && chk_idx_r == last_w) || cmd.res_full) begin
      res_granted_r <= '0;
      res_status_r  <= ST_FULL;
    end else if (cmd.res_range) begin
      res_granted_r <= '0;
      res_status_r  <= ST_RANGE;
    end else if (cmd.res_zero) begin
      res_granted_r <= '0;
      res_status_r  <= ST_OK;
    end
    if (cmd.out_load) begin
      out_granted_r <= res_granted_r;
      out_status_r  <= res_status_r;
    end
  end

  assign sts.n_zero     = (n == '0);
  assign sts.found      = chk_v_r && any_free;
  assign sts.exhausted  = chk_v_r && !any_free && (chk_idx_r == last_w);
  assign sts.bn_bad     = (bn_r == '0) || (bn_r > n);
  assign sts.sweep_last = (sweep_addr_r == LAST_WORD);

  assign out_granted_block = out_granted_r;
  assign out_status        = out_status_r;

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan && sts.found |=> res_status_r == ST_OK)
    else $error("allocation hit did not record an ok status");

  a_exhausted_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan && sts.exhausted |=> res_status_r == ST_FULL && res_granted_r == '0)
    else $error("exhausted scan did not record a full map");

endmodule

// ----- hdl/bba_ctrl.sv -----
// Controller state machine that sequences allocate, free, format and the post-reset clear.
module bba_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [bba_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bba_pkg::bba_cmd_t          cmd,
  input  bba_pkg::bba_sts_t          sts
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_FMT_MUL,
    S_FMT_RSV,
    S_FMT_SWEEP,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_func)
            FUNC_ALLOC: begin
              if (sts.n_zero) begin
                cmd.res_full = 1'b1;
                state_nxt    = S_RESP;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            FUNC_FREE: begin
              state_nxt = S_FREE_RD;
            end
            FUNC_FORMAT: begin
              state_nxt = S_FMT_MUL;
            end
            default: begin
              cmd.res_zero = 1'b1;
              state_nxt    = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.exhausted) begin
          state_nxt = S_RESP;
        end
      end
      S_FREE_RD: begin
        if (sts.bn_bad) begin
          cmd.res_range = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          state_nxt = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.free_wr  = 1'b1;
        cmd.res_zero = 1'b1;
        state_nxt    = S_RESP;
      end
      S_FMT_MUL: begin
        cmd.fmt_mul = 1'b1;
        state_nxt   = S_FMT_RSV;
      end
      S_FMT_RSV: begin
        cmd.fmt_rsv = 1'b1;
        state_nxt   = S_FMT_SWEEP;
      end
      S_FMT_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken before the map was cleared");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one was in progress");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result word not presented");

endmodule

// ----- hdl/block_bitmap_allocator_top.sv -----
// Top level of the first-fit bitmap block allocator.
// Requests arrive as words on in_ch (func, block_number) and each gives exactly one
// result word on out_ch (granted_block, status); both channels use valid/ready.
// Allocate takes the lowest free block below min(block_count, MAX_BLOCKS), marks it
// used and returns its one-based number; a full map returns 0 with status full.
// Free clears the bit of a one-based block number, or reports out of range.
// Format clears the map, marks blocks 0 to 1+ceil(min(count,MAX_BLOCKS)/10) used.
// The map is held as 64-bit memory words with one read and one write port.
// Allocate reads one map word per cycle from word 0 up until a free bit is found or
// the last word is checked; free reads and rewrites one word (read-modify-write), or
// reports out of range without writing; format writes one word per cycle over the
// whole map; other codes, and allocate with a zero count, go straight to the result.
// One request is worked on at a time: the next one is taken in the cycle after the
// result is loaded. After reset the map is cleared with in_ch ready low.
// block_count resets to 4096; the user is to write it through cfg_wr_en/cfg_wr_data
// only when idle, as the block itself does not enforce this.
// The result register lets the next request be accepted while out_ch is stalled;
// that request finishes its work and then waits until the result word is taken.
module block_bitmap_allocator_top #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bba_pkg::BLOCK_W-1:0] cfg_wr_data,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_block_number   (in_ch.block_number),
    .cmd               (cmd),
    .sts               (sts),
    .out_granted_block (out_ch.granted_block),
    .out_status        (out_ch.status)
  );

endmodule

// ----- tb/bba_checker.sv -----
`timescale 1ns / 100ps
// Watches both channels and the count register, predicts every result word and compares.
module bba_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bba_pkg::BLOCK_W-1:0] cfg_wr_data,
  bba_in_if                           in_ch,
  bba_out_if                          out_ch,
  output int                          fail_count,
  output int                          pending_count
);
  import bba_pkg::*;

  localparam int MAP_SIZE      = MAX_BLOCKS_DEF;
  localparam int RESERVED_HEAD = 2;
  localparam int INODE_SPAN    = 10;

  typedef struct packed {
    logic [BLOCK_W-1:0]  granted;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  logic [MAP_SIZE-1:0] used_bits;
  logic [BLOCK_W-1:0]  count_reg;
  alloc_result_t       awaited_results[$];
  int                  mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
  endtask

  task automatic apply_request(input logic [FUNC_W-1:0] f, input logic [BLOCK_W-1:0] bn,
                               output alloc_result_t res);
    int n;
    int reserve;
    int i;
    n = (int'(count_reg) > MAP_SIZE) ? MAP_SIZE : int'(count_reg);
    res.granted = '0;
    res.status  = ST_OK;
    case (f)
      FUNC_ALLOC: begin
        res.status = ST_FULL;
        for (i = 0; i < n; i++) begin
          if (!used_bits[i]) begin
            used_bits[i] = 1'b1;
            res.granted  = BLOCK_W'(i + 1);
            res.status   = ST_OK;
            break;
          end
        end
      end
      FUNC_FREE: begin
        if (bn == '0 || int'(bn) > n) begin
          res.status = ST_RANGE;
        end else begin
          used_bits[int'(bn) - 1] = 1'b0;
        end
      end
      FUNC_FORMAT: begin
        reserve = RESERVED_HEAD + (n + INODE_SPAN - 1) / INODE_SPAN;
        if (reserve > MAP_SIZE) reserve = MAP_SIZE;
        used_bits = '0;
        for (i = 0; i < reserve; i++) used_bits[i] = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      used_bits = '0;
      count_reg = BLOCK_COUNT_RST;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) count_reg = cfg_wr_data;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding", int'(out_ch.granted_block), -1);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.granted_block !== want.granted) begin
            report_mismatch("granted_block", int'(out_ch.granted_block), int'(want.granted));
          end
          if (out_ch.status !== want.status) begin
            report_mismatch("status", int'(out_ch.status), int'(want.status));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.func, in_ch.block_number, want);
        awaited_results.push_back(want);
      end
    end
    pending_count <= awaited_results.size();
    fail_count    <= mismatches;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and result traffic, and verdict.
module testbench;
  import bba_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int MAP_SIZE    = MAX_BLOCKS_DEF;
  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [BLOCK_W-1:0] cfg_wr_data;
  int                 fail_count;
  int                 pending_count;
  int                 gap_max = 5;
  int                 stall_max = 5;
  int                 cur_count = 4096;
  bit                 hold_output = 1'b0;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  block_bitmap_allocator_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  bba_checker alloc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  task automatic send(input logic [FUNC_W-1:0] f, input logic [BLOCK_W-1:0] bn);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.block_number <= bn;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    drain();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= BLOCK_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_count   = value;
  endtask

  task automatic random_item(input int alloc_pct);
    int n;
    int r;
    logic [FUNC_W-1:0]  f;
    logic [BLOCK_W-1:0] bn;
    n  = (cur_count > MAP_SIZE) ? MAP_SIZE : cur_count;
    r  = $urandom_range(0, 99);
    bn = BLOCK_W'($urandom);
    if (r < alloc_pct) begin
      f = FUNC_ALLOC;
    end else if (r < 94) begin
      f = FUNC_FREE;
      if (r == 88) begin
        bn = '0;
      end else if (r == 89) begin
        bn = BLOCK_W'(n + 1);
      end else if (r < 88 && n > 0) begin
        if ($urandom_range(0, 1) == 0) begin
          bn = BLOCK_W'($urandom_range(1, (n < 600) ? n : 600));
        end else begin
          bn = BLOCK_W'($urandom_range(1, n));
        end
      end
    end else if (r < 97) begin
      f = FUNC_FORMAT;
    end else begin
      f = FUNC_UNUSED;
    end
    send(f, bn);
  endtask

  task automatic run_phase(input int count_value, input int items, input int alloc_pct);
    write_count(count_value);
    send(FUNC_FORMAT, BLOCK_W'($urandom));
    repeat (items) random_item(alloc_pct);
  endtask

  initial begin
    int stall;
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, stall_max);
      if (hold_output && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_ALLOC;
    in_ch.block_number = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_FORMAT, 13'd8191);
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_FREE, 13'd413);
    send(FUNC_FREE, 13'd413);
    send(FUNC_FREE, 13'd0);
    send(FUNC_FREE, 13'd4096);
    send(FUNC_FREE, 13'd4097);
    send(FUNC_FREE, 13'd8191);
    send(FUNC_UNUSED, 13'd8191);
    send(FUNC_ALLOC, 13'd0);
    write_count(0);
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_FREE, 13'd1);
    send(FUNC_FORMAT, BLOCK_W'($urandom));
    write_count(1);
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_FREE, 13'd1);
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    write_count(8191);
    send(FUNC_FORMAT, BLOCK_W'($urandom));
    send(FUNC_ALLOC, BLOCK_W'($urandom));
    send(FUNC_FREE, 13'd4096);
    send(FUNC_FREE, 13'd4097);

    run_phase(4096, 200, 80);
    run_phase(20, 100, 60);
    drain();
    hold_output = 1'b1;
    run_phase(65, 100, 60);
    run_phase(2, 50, 50);
    run_phase(130, 100, 65);
    gap_max   = 0;
    stall_max = 0;
    run_phase(1, 50, 50);
    run_phase(12, 50, 60);
    gap_max   = 5;
    stall_max = 5;
    run_phase($urandom_range(1, 4096), 100, 75);
    run_phase($urandom_range(4097, 8191), 100, 75);

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("block_bitmap_allocator_top test passed");
    end else begin
      $display("block_bitmap_allocator_top test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("block_bitmap_allocator_top test failed");
    $finish;
  end

endmodule
